[hw/rtl/rsn_pkg.sv]
// Shared types and constants for the recurrent sigmoid neuron.
// Holds the request/result structs and the fixed-point PLAN breakpoints.
// No dependencies.
package rsn_pkg;

    // Most terms summed between two last-term markers
    localparam int MAX_TERMS = 256;
    localparam int DATA_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    // Q16.24 accumulator, sized so MAX_TERMS products cannot overflow
    localparam int ACC_W     = PROD_W + $clog2(MAX_TERMS);
    localparam int OUT_W     = 16;
    // Q0.24 probability before rounding; holds 1.0 exactly
    localparam int P_W       = 25;

    // PLAN breakpoints on |sum|, Q16.24
    localparam logic [ACC_W-1:0] BREAK_HI  = ACC_W'(64'd83886080);  // 5.0
    localparam logic [ACC_W-1:0] BREAK_MID = ACC_W'(64'd39845888);  // 2.375
    localparam logic [ACC_W-1:0] BREAK_LO  = ACC_W'(64'd16777216);  // 1.0

    // PLAN offsets and unity, Q0.24
    localparam logic [P_W-1:0] ONE_Q24 = P_W'(32'd16777216);
    localparam logic [P_W-1:0] OFS_HI  = P_W'(32'd14155776);  // 0.84375
    localparam logic [P_W-1:0] OFS_MID = P_W'(32'd10485760);  // 0.625
    localparam logic [P_W-1:0] OFS_LO  = P_W'(32'd8388608);   // 0.5

    // Rounding constant: half an output LSB
    localparam logic [P_W:0] ROUND_HALF = (P_W + 1)'(32'd128);
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // One input term
    typedef struct packed {
        logic signed [DATA_W-1:0] activation;
        logic signed [DATA_W-1:0] weight;
        logic                     is_recurrent;
        logic                     last_term;
    } t_term_req;

    // One neuron result
    typedef struct packed {
        logic        [OUT_W-1:0] neuron_output;
        logic signed [ACC_W-1:0] pre_activation;
    } t_neuron_res;

endpackage

[hw/rtl/rsn_plan_sigmoid.sv]
// Three-stage PLAN sigmoid: magnitude, segment evaluation, rounding.
// Depends on rsn_pkg; ends in the result register seen at the top level.
module rsn_plan_sigmoid import rsn_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [ACC_W-1:0] i_sum,
    output logic                    o_valid,
    output t_neuron_res             o_result
);

    logic                    r_a_valid;
    logic [ACC_W-1:0]        r_abs;
    logic                    r_a_neg;
    logic signed [ACC_W-1:0] r_a_sum;

    logic                    r_p_valid;
    logic [P_W-1:0]          r_p;
    logic signed [ACC_W-1:0] r_p_sum;

    logic                    r_o_valid;
    t_neuron_res             r_o_res;

    logic [ACC_W-1:0] n_abs;
    logic [P_W-1:0]   n_pos;
    logic [P_W-1:0]   n_p;
    logic [P_W:0]     n_round;
    logic [OUT_W-1:0] n_out;

    // Take the magnitude of the sum
    assign n_abs = i_sum[ACC_W-1] ? ACC_W'(-i_sum) : ACC_W'(i_sum);

    // Evaluate the linear segment for |sum|; only the low 27 bits matter below 5.0
    always_comb begin
        if (r_abs >= BREAK_HI) begin
            n_pos = ONE_Q24;
        end else if (r_abs >= BREAK_MID) begin
            n_pos = P_W'(r_abs[26:5]) + OFS_HI;
        end else if (r_abs >= BREAK_LO) begin
            n_pos = P_W'(r_abs[26:3]) + OFS_MID;
        end else begin
            n_pos = P_W'(r_abs[26:2]) + OFS_LO;
        end
        n_p = r_a_neg ? (ONE_Q24 - n_pos) : n_pos;
    end

    // Round to Q0.16 and saturate an exact one
    always_comb begin
        n_round = {1'b0, r_p} + ROUND_HALF;
        if (n_round[P_W:8] > (P_W - 7)'(OUT_MAX)) begin
            n_out = OUT_MAX;
        end else begin
            n_out = n_round[8 +: OUT_W];
        end
    end

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_p_valid <= r_a_valid;
            r_o_valid <= r_p_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs                  <= n_abs;
            r_a_neg                <= i_sum[ACC_W-1];
            r_a_sum                <= i_sum;
            r_p                    <= n_p;
            r_p_sum                <= r_a_sum;
            r_o_res.neuron_output  <= n_out;
            r_o_res.pre_activation <= r_p_sum;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o_res;

    // Sign of the sum picks the half of the curve
    a_neg_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_res.pre_activation[ACC_W-1]) |->
            (r_o_res.neuron_output <= 16'd32768))
        else $error("negative sum produced output above one half");

    a_pos_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_res.pre_activation[ACC_W-1]) |->
            (r_o_res.neuron_output >= 16'd32768))
        else $error("non-negative sum produced output below one half");

    // A held pipeline keeps its finished result
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en && r_o_valid) |=> r_o_valid)
        else $error("result lost while the pipeline was held");

endmodule

[hw/rtl/recurrent_sigmoid_neuron.sv]
// Top level of the recurrent sigmoid neuron: term MAC and result pipeline.
// Depends on rsn_pkg and rsn_plan_sigmoid.
//
//   channel | signals                               | carries
//   --------+---------------------------------------+---------------------------
//   term in | i_in_valid / o_in_ready / i_in_data   | t_term_req, one per term
//   result  | o_out_valid / i_out_ready / o_out_data| t_neuron_res, per last term
//   config  | i_cfg_we / i_cfg_wdata                | drop_recurrent
//
// One term is taken per cycle while no result waits in the skid register; the 40-bit accumulate loop sets it.
// After its last term is taken, a result passes the input register and then the
// multiply, accumulate, magnitude, segment and round stages.
// Reset clears the accumulator and all valid flags. A result the receiver does
// not take moves to a skid register; while it waits there, the whole pipeline
// holds and o_in_ready is low.
module recurrent_sigmoid_neuron import rsn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_term_req   i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_neuron_res o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    logic w_adv;
    logic w_accept;
    logic w_pipe_valid;
    t_neuron_res w_pipe_res;

    logic                    r_drop;
    logic                    r_in_valid;
    t_term_req               r_in;
    logic                    r_prod_valid;
    logic                    r_prod_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_sum_valid;
    logic signed [ACC_W-1:0] r_sum;
    logic                    r_skid_valid;
    t_neuron_res             r_skid;

    logic                    n_keep;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0] n_acc;

    // Move everything forward unless a result is parked in the skid register
    assign w_adv      = !r_skid_valid;
    assign o_in_ready = w_adv;
    assign w_accept   = i_in_valid && w_adv;

    // Show the parked result first, else the pipeline's result
    assign o_out_valid = r_skid_valid || w_pipe_valid;
    assign o_out_data  = r_skid_valid ? r_skid : w_pipe_res;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= 1'b0;
        end else if (i_cfg_we) begin
            r_drop <= i_cfg_wdata;
        end
    end

    // Drop recurrent terms for an output-layer neuron
    assign n_keep = !(r_in.is_recurrent && r_drop);
    assign n_prod = n_keep ? (PROD_W'(r_in.activation) * PROD_W'(r_in.weight)) : '0;

    // Accumulate the product
    assign n_acc = r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
            r_sum_valid  <= 1'b0;
            r_acc        <= '0;
        end else if (w_adv) begin
            r_in_valid   <= w_accept;
            r_prod_valid <= r_in_valid;
            r_sum_valid  <= r_prod_valid && r_prod_last;
            if (r_prod_valid) begin
                r_acc <= r_prod_last ? '0 : n_acc;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in        <= i_in_data;
            r_prod      <= n_prod;
            r_prod_last <= r_in.last_term;
            r_sum       <= n_acc;
        end
    end

    // Park a result the receiver does not take; release it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_pipe_valid && !i_out_ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid && w_pipe_valid && !i_out_ready) begin
            r_skid <= w_pipe_res;
        end
    end

    rsn_plan_sigmoid u_sigmoid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (r_sum_valid),
        .i_sum    (r_sum),
        .o_valid  (w_pipe_valid),
        .o_result (w_pipe_res)
    );

    // Accumulator starts over after a last term
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_prod_valid && r_prod_last) |=> (r_acc == '0))
        else $error("accumulator not cleared after last term");

    // A dropped recurrent term contributes nothing
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_valid && r_in.is_recurrent && r_drop) |=> (r_prod == '0))
        else $error("dropped recurrent term added a nonzero product");

    // A waiting result stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("waiting result changed or dropped");

endmodule
